/* rtl/core/bhsr_pkg.sv */
// Shared types and constants for the button-hold speed ramp.
package bhsr_pkg;

    localparam int FREQ_BITS_DEF  = 20;
    localparam int TIMER_BITS_DEF = 16;
    localparam int STEP_BITS      = 16;

    // Increment growth is step*1000/3500, reduced to step*2/7.
    localparam int GROW_NUM  = 1000;
    localparam int GROW_DEN  = 3500;
    localparam int GROW_GCD  = 500;
    localparam int GROW_ADD  = GROW_NUM / GROW_GCD;
    localparam int GROW_DIV  = GROW_DEN / GROW_GCD;
    localparam int REM_BITS  = $clog2(GROW_DIV);

    // Band below the new maximum that resets the ramp.
    localparam int NEAR_BAND = 300;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_DIR    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_SPD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_IVL   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_INC  = 2'd3;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_SPEED = 2'd3
    } t_motor_cmd;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_ONE  = 2'd1,
        STEP_ZERO = 2'd2,
        STEP_INC  = 2'd3
    } t_step_op;

    typedef struct packed {
        t_motor_cmd cmd;
        logic       dir;
    } t_ctl;

endpackage

/* rtl/core/bhsr_step_track.sv */
// Ramp step counter that keeps step*2/7 as a running quotient and remainder.
module bhsr_step_track
    import bhsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_step_op             i_op,
    output logic [STEP_BITS-1:0] o_grow
);

    logic [STEP_BITS-1:0] r_step, n_step;
    logic [STEP_BITS-1:0] r_quo,  n_quo;
    logic [REM_BITS-1:0]  r_rem,  n_rem;
    logic [REM_BITS:0]    w_rem_sum;

    assign w_rem_sum = {1'b0, r_rem} + (REM_BITS+1)'(GROW_ADD);

    always_comb begin
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        unique case (i_op)
            STEP_HOLD: ;
            STEP_ONE: begin
                n_step = STEP_BITS'(1);
                n_quo  = '0;
                n_rem  = REM_BITS'(GROW_ADD);
            end
            STEP_ZERO: begin
                n_step = '0;
                n_quo  = '0;
                n_rem  = '0;
            end
            STEP_INC: begin
                // step saturates; quotient/remainder follow only on a real increment
                if (r_step != {STEP_BITS{1'b1}}) begin
                    n_step = r_step + 1'b1;
                    if (w_rem_sum >= (REM_BITS+1)'(GROW_DIV)) begin
                        n_quo = r_quo + 1'b1;
                        n_rem = REM_BITS'(w_rem_sum - (REM_BITS+1)'(GROW_DIV));
                    end else begin
                        n_rem = w_rem_sum[REM_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
        end else begin
            r_step <= n_step;
            r_quo  <= n_quo;
            r_rem  <= n_rem;
        end
    end

    assign o_grow = r_quo;

endmodule

/* rtl/core/bhsr_ramp_logic.sv */
// Next-state and result logic for one tick or set-max request.
module bhsr_ramp_logic
    import bhsr_pkg::*;
#(
    parameter int FREQ_BITS  = FREQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_action,
    input  logic                  i_pressed,
    input  logic                  i_changed,
    input  logic [FREQ_BITS-1:0]  i_new_max,
    input  logic                  i_run_dir,
    input  logic [FREQ_BITS-1:0]  i_start_speed,
    input  logic [TIMER_BITS-1:0] i_ramp_ivl,
    input  logic [FREQ_BITS-1:0]  i_start_inc,
    input  logic [FREQ_BITS-1:0]  i_freq,
    input  logic [FREQ_BITS-1:0]  i_limit,
    input  logic [FREQ_BITS-1:0]  i_inc,
    input  logic [TIMER_BITS-1:0] i_timer,
    input  logic [STEP_BITS-1:0]  i_grow,
    output logic [FREQ_BITS-1:0]  o_freq,
    output logic [FREQ_BITS-1:0]  o_limit,
    output logic [FREQ_BITS-1:0]  o_inc,
    output logic [TIMER_BITS-1:0] o_timer,
    output t_step_op              o_step_op,
    output t_ctl                  o_ctl
);

    localparam int NEAR_W = FREQ_BITS + 2;
    localparam int SUM_W  = ((FREQ_BITS > STEP_BITS) ? FREQ_BITS : STEP_BITS) + 1;

    logic [TIMER_BITS-1:0] w_timer_dec;
    logic [NEAR_W-1:0]     w_near_sum;
    logic                  w_near;
    logic                  w_overshoot;
    logic [SUM_W-1:0]      w_inc_sum;
    logic [FREQ_BITS-1:0]  w_inc_grown;
    logic [FREQ_BITS:0]    w_freq_sum;
    logic [FREQ_BITS-1:0]  w_freq_grown;

    assign w_timer_dec = (i_timer != '0) ? (i_timer - 1'b1) : '0;
    assign w_near_sum  = NEAR_W'(i_freq) + NEAR_W'(NEAR_BAND);
    assign w_near      = w_near_sum > NEAR_W'(i_new_max);
    assign w_overshoot = ({1'b0, i_freq} + {1'b0, i_inc}) > {1'b0, i_limit};

    // saturating increment growth, then saturating frequency add
    assign w_inc_sum    = SUM_W'(i_inc) + SUM_W'(i_grow);
    assign w_inc_grown  = (|w_inc_sum[SUM_W-1:FREQ_BITS]) ? {FREQ_BITS{1'b1}}
                                                          : w_inc_sum[FREQ_BITS-1:0];
    assign w_freq_sum   = {1'b0, i_freq} + {1'b0, w_inc_grown};
    assign w_freq_grown = w_freq_sum[FREQ_BITS] ? {FREQ_BITS{1'b1}}
                                                : w_freq_sum[FREQ_BITS-1:0];

    always_comb begin
        o_freq    = i_freq;
        o_limit   = i_limit;
        o_inc     = i_inc;
        o_timer   = w_timer_dec;
        o_step_op = STEP_HOLD;
        o_ctl.cmd = CMD_NONE;
        o_ctl.dir = 1'b0;
        if (i_action) begin
            // set-max does not advance the timer
            o_timer = i_timer;
            o_limit = i_new_max;
            if (w_near) begin
                o_inc     = i_start_inc;
                o_step_op = STEP_ZERO;
            end
        end else begin
            priority if (i_changed && i_pressed) begin
                o_step_op = STEP_ONE;
                o_inc     = i_start_inc;
                o_timer   = i_ramp_ivl;
                o_freq    = i_start_speed;
                o_ctl.cmd = CMD_RUN;
                o_ctl.dir = i_run_dir;
            end else if (i_changed) begin
                o_freq    = '0;
                o_ctl.cmd = CMD_STOP;
            end else if (i_freq > i_limit) begin
                o_freq    = i_limit;
                o_ctl.cmd = CMD_SPEED;
            end else if (i_pressed && (w_timer_dec == '0)) begin
                priority if (i_freq == i_limit) begin
                    o_ctl.cmd = CMD_NONE;
                end else if (w_overshoot) begin
                    // land on the limit, timer stays elapsed
                    o_freq    = i_limit;
                    o_ctl.cmd = CMD_SPEED;
                end else begin
                    o_timer   = i_ramp_ivl;
                    o_inc     = w_inc_grown;
                    o_freq    = w_freq_grown;
                    o_step_op = STEP_INC;
                    o_ctl.cmd = CMD_SPEED;
                end
            end else begin
                o_ctl.cmd = CMD_NONE;
            end
        end
    end

endmodule

/* rtl/core/button_hold_speed_ramp_core.sv */
// Top level of the button-hold speed ramp: request register, state, result register.
// An accepted request is held in the request register; its result is then loaded into the result
// register, which can stall on i_out_stall.
// Throughput: one request per cycle while the output is not stalled; the state update goes
// through the ramp logic between the request register and the state registers.
// Reset: synchronous, active low; clears configuration, ramp state and both valid flags.
module button_hold_speed_ramp_core
    import bhsr_pkg::*;
#(
    parameter int FREQ_BITS  = FREQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    localparam int CFG_BITS  = (FREQ_BITS > TIMER_BITS) ? FREQ_BITS : TIMER_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_action,
    input  logic                    i_button_pressed,
    input  logic                    i_button_changed,
    input  logic [FREQ_BITS-1:0]    i_new_max_freq,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_motor_command,
    output logic                    o_motor_direction,
    output logic [FREQ_BITS-1:0]    o_motor_freq
);

    // configuration
    logic                  r_run_dir;
    logic [FREQ_BITS-1:0]  r_start_speed;
    logic [TIMER_BITS-1:0] r_ramp_ivl;
    logic [FREQ_BITS-1:0]  r_start_inc;

    // request register
    logic                  r_in_vld;
    logic                  r_in_action;
    logic                  r_in_pressed;
    logic                  r_in_changed;
    logic [FREQ_BITS-1:0]  r_in_max;

    // ramp state
    logic [FREQ_BITS-1:0]  r_freq,  n_freq;
    logic [FREQ_BITS-1:0]  r_limit, n_limit;
    logic [FREQ_BITS-1:0]  r_inc,   n_inc;
    logic [TIMER_BITS-1:0] r_timer, n_timer;

    // result register
    logic                  r_out_vld;
    t_ctl                  r_out_ctl;
    logic [FREQ_BITS-1:0]  r_out_freq;

    logic                  w_out_load;
    logic                  w_proc;
    t_step_op              w_step_op;
    t_step_op              w_step_cmd;
    t_ctl                  w_ctl;
    logic [STEP_BITS-1:0]  w_grow;

    assign w_out_load = !r_out_vld || !i_out_stall;
    assign w_proc     = r_in_vld && w_out_load;
    assign o_in_stall = r_in_vld && !w_out_load;
    assign w_step_cmd = w_proc ? w_step_op : STEP_HOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_dir     <= 1'b0;
            r_start_speed <= '0;
            r_ramp_ivl    <= '0;
            r_start_inc   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RUN_DIR:   r_run_dir     <= i_cfg_data[0];
                CFG_START_SPD: r_start_speed <= i_cfg_data[FREQ_BITS-1:0];
                CFG_RAMP_IVL:  r_ramp_ivl    <= i_cfg_data[TIMER_BITS-1:0];
                CFG_START_INC: r_start_inc   <= i_cfg_data[FREQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_action  <= i_action;
            r_in_pressed <= i_button_pressed;
            r_in_changed <= i_button_changed;
            r_in_max     <= i_new_max_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= '0;
            r_limit <= '0;
            r_inc   <= '0;
            r_timer <= '0;
        end else if (w_proc) begin
            r_freq  <= n_freq;
            r_limit <= n_limit;
            r_inc   <= n_inc;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= w_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_ctl  <= w_ctl;
            r_out_freq <= n_freq;
        end
    end

    bhsr_ramp_logic #(
        .FREQ_BITS  (FREQ_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_ramp_logic (
        .i_action      (r_in_action),
        .i_pressed     (r_in_pressed),
        .i_changed     (r_in_changed),
        .i_new_max     (r_in_max),
        .i_run_dir     (r_run_dir),
        .i_start_speed (r_start_speed),
        .i_ramp_ivl    (r_ramp_ivl),
        .i_start_inc   (r_start_inc),
        .i_freq        (r_freq),
        .i_limit       (r_limit),
        .i_inc         (r_inc),
        .i_timer       (r_timer),
        .i_grow        (w_grow),
        .o_freq        (n_freq),
        .o_limit       (n_limit),
        .o_inc         (n_inc),
        .o_timer       (n_timer),
        .o_step_op     (w_step_op),
        .o_ctl         (w_ctl)
    );

    bhsr_step_track u_step_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_step_cmd),
        .o_grow  (w_grow)
    );

    assign o_out_valid       = r_out_vld;
    assign o_motor_command   = r_out_ctl.cmd;
    assign o_motor_direction = r_out_ctl.dir;
    assign o_motor_freq      = r_out_freq;

endmodule
